[rtl/core/dtfp_pkg.sv]
// ----------------------------------------------------------------------------
// dtfp_pkg
// Shared types and constants for the decimal text to fixed point converter.
// ----------------------------------------------------------------------------
package dtfp_pkg;

	localparam int CHAR_W   = 8;
	localparam int DIGITS_W = 5;
	localparam int VALUE_W  = 64;
	localparam int FRAC_W   = 60;
	localparam int GROUP_W  = 3;

	localparam logic [DIGITS_W-1:0] MAX_DIGITS   = 5'd18;
	localparam logic [DIGITS_W-1:0] RESET_DIGITS = 5'd4;

	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

	localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_BODY,
		PH_CLOSED,
		PH_TRAIL
	} dtfp_phase_t;

	typedef struct packed {
		logic [VALUE_W-1:0] int_mag;
		logic [FRAC_W-1:0]  frac_mag;
		logic               round_up;
		logic               negative;
		logic               syntax_ok;
	} dtfp_snap_t;

	function automatic logic [FRAC_W-1:0] pow10(input logic [DIGITS_W-1:0] idx);
		logic [FRAC_W-1:0] p;
		case (idx)
			5'd0:    p = 60'd1;
			5'd1:    p = 60'd10;
			5'd2:    p = 60'd100;
			5'd3:    p = 60'd1000;
			5'd4:    p = 60'd10000;
			5'd5:    p = 60'd100000;
			5'd6:    p = 60'd1000000;
			5'd7:    p = 60'd10000000;
			5'd8:    p = 60'd100000000;
			5'd9:    p = 60'd1000000000;
			5'd10:   p = 60'd10000000000;
			5'd11:   p = 60'd100000000000;
			5'd12:   p = 60'd1000000000000;
			5'd13:   p = 60'd10000000000000;
			5'd14:   p = 60'd100000000000000;
			5'd15:   p = 60'd1000000000000000;
			5'd16:   p = 60'd10000000000000000;
			5'd17:   p = 60'd100000000000000000;
			default: p = 60'd1000000000000000000;
		endcase
		return p;
	endfunction

endpackage

[rtl/core/dtfp_char_if.sv]
// ----------------------------------------------------------------------------
// dtfp_char_if
// Character channel: one text byte per word, with an end-of-text mark.
// ----------------------------------------------------------------------------
interface dtfp_char_if;
	import dtfp_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);

endinterface

[rtl/core/dtfp_result_if.sv]
// ----------------------------------------------------------------------------
// dtfp_result_if
// Result channel: scaled signed value and a valid flag per word.
// ----------------------------------------------------------------------------
interface dtfp_result_if;
	import dtfp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] scaled_value;
	logic                      valid_res;

	modport source (output valid, output scaled_value, output valid_res, input ready);
	modport sink   (input valid, input scaled_value, input valid_res, output ready);

endinterface

[rtl/core/dtfp_parser.sv]
// ----------------------------------------------------------------------------
// dtfp_parser
// Per-character parse state: sign, grouping, point and the scaled integer
// and fraction accumulators. Gives a snapshot of the state after each byte.
// ----------------------------------------------------------------------------
module dtfp_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [dtfp_pkg::CHAR_W-1:0]       char_code,
	input  logic                              is_last,
	input  logic [dtfp_pkg::DIGITS_W-1:0]     cfg_digits,
	output dtfp_pkg::dtfp_snap_t              snap
);
	import dtfp_pkg::*;

	dtfp_phase_t          phase_q, phase_d;
	logic                 neg_q, neg_n;
	logic                 par_q, par_n;
	logic [VALUE_W-1:0]   int_q, int_n;
	logic [FRAC_W-1:0]    frac_q, frac_n;
	logic [DIGITS_W-1:0]  fc_q, fc_n;
	logic                 round_q, round_n;
	logic                 saw_int_q, saw_int_n;
	logic                 saw_pt_q, saw_pt_n;
	logic                 saw_comma_q, saw_comma_n;
	logic [GROUP_W-1:0]   grp_q, grp_n;
	logic                 err_q, err_n;
	logic [DIGITS_W-1:0]  act_q, act_n;

	logic                 blank, is_digit, body_hit;
	logic [3:0]           dig;
	logic [DIGITS_W-1:0]  clamped, act;
	logic [FRAC_W-1:0]    pow_a, pow_f;
	logic [VALUE_W-1:0]   dig_int, dig_frac;
	logic [VALUE_W+3:0]   int_ext, cand, limit_ext;

	function automatic logic [VALUE_W-1:0] mul_digit(
		input logic [FRAC_W-1:0] p,
		input logic [3:0]        d
	);
		logic [VALUE_W-1:0] pe;
		pe = {{(VALUE_W-FRAC_W){1'b0}}, p};
		return (d[0] ? pe : '0) + (d[1] ? pe << 1 : '0) +
			(d[2] ? pe << 2 : '0) + (d[3] ? pe << 3 : '0);
	endfunction

	assign blank    = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
	assign is_digit = char_code >= CH_ZERO && char_code <= CH_NINE;
	assign dig      = is_digit ? char_code[3:0] : 4'd0;
	assign clamped  = (cfg_digits > MAX_DIGITS) ? MAX_DIGITS : cfg_digits;
	assign act      = (phase_q == PH_LEAD) ? clamped : act_q;

	assign pow_a    = pow10(act);
	assign pow_f    = pow10(5'(act - fc_q - 5'd1));
	assign dig_int  = mul_digit(pow_a, dig);
	assign dig_frac = mul_digit(pow_f, dig);

	// integer digit check on the scaled value: int*10 + d*10^act within limit
	assign int_ext   = {4'b0, int_q};
	assign cand      = (int_ext << 3) + (int_ext << 1) + {4'b0, dig_int};
	assign limit_ext = {4'b0, (neg_q ? NEG_LIMIT : POS_LIMIT)};

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_LEAD: begin
				if (!blank) phase_d = PH_BODY;
			end
			PH_BODY: begin
				if (blank) begin
					if (!par_q) phase_d = PH_TRAIL;
				end else if (char_code == CH_RPAREN && par_q) begin
					phase_d = PH_CLOSED;
				end
			end
			PH_CLOSED: begin
				if (blank) phase_d = PH_TRAIL;
			end
			PH_TRAIL: begin
				phase_d = PH_TRAIL;
			end
			default: phase_d = phase_q;
		endcase
	end

	// state after this byte
	always_comb begin
		neg_n       = neg_q;
		par_n       = par_q;
		int_n       = int_q;
		frac_n      = frac_q;
		fc_n        = fc_q;
		round_n     = round_q;
		saw_int_n   = saw_int_q;
		saw_pt_n    = saw_pt_q;
		saw_comma_n = saw_comma_q;
		grp_n       = grp_q;
		err_n       = err_q;
		act_n       = act_q;
		body_hit    = 1'b0;

		unique case (phase_q)
			PH_LEAD: begin
				if (!blank) begin
					act_n = clamped;
					if (char_code == CH_LPAREN) begin
						par_n = 1'b1;
					end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
						neg_n = (char_code == CH_MINUS);
					end else begin
						body_hit = 1'b1;
					end
				end
			end
			PH_BODY: begin
				if (blank) begin
					if (par_q) err_n = 1'b1;
				end else if (!(char_code == CH_RPAREN && par_q)) begin
					body_hit = 1'b1;
				end
			end
			PH_CLOSED: begin
				if (!blank) err_n = 1'b1;
			end
			PH_TRAIL: begin
				if (!blank) err_n = 1'b1;
			end
			default: err_n = 1'b1;
		endcase

		if (body_hit) begin
			if (char_code == CH_POINT) begin
				if (saw_pt_q) begin
					err_n = 1'b1;
				end else begin
					if (saw_comma_q && grp_q != 3'd3) err_n = 1'b1;
					saw_pt_n = 1'b1;
				end
			end else if (saw_pt_q) begin
				if (!is_digit) begin
					err_n = 1'b1;
				end else begin
					if (fc_q < act) frac_n = frac_q + dig_frac[FRAC_W-1:0];
					else if (fc_q == act) round_n = (dig >= 4'd5);
					if (fc_q <= act) fc_n = fc_q + 5'd1;
				end
			end else if (char_code == CH_COMMA) begin
				if (!saw_comma_q) begin
					if (grp_q == 3'd0 || grp_q > 3'd3) err_n = 1'b1;
					saw_comma_n = 1'b1;
				end else if (grp_q != 3'd3) begin
					err_n = 1'b1;
				end
				grp_n = '0;
			end else if (is_digit) begin
				if (grp_q < 3'd4) grp_n = grp_q + 3'd1;
				saw_int_n = 1'b1;
				if (cand > limit_ext) err_n = 1'b1;
				else int_n = cand[VALUE_W-1:0];
			end else begin
				err_n = 1'b1;
			end
		end
	end

	always_comb begin
		snap.int_mag   = int_n;
		snap.frac_mag  = frac_n;
		snap.round_up  = round_n;
		snap.negative  = neg_n;
		snap.syntax_ok = !err_n && phase_d != PH_LEAD &&
			!(par_n && phase_d != PH_CLOSED && phase_d != PH_TRAIL) &&
			(saw_int_n || fc_n != '0) &&
			!(!saw_pt_n && saw_comma_n && grp_n != 3'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			neg_q       <= 1'b0;
			par_q       <= 1'b0;
			int_q       <= '0;
			frac_q      <= '0;
			fc_q        <= '0;
			round_q     <= 1'b0;
			saw_int_q   <= 1'b0;
			saw_pt_q    <= 1'b0;
			saw_comma_q <= 1'b0;
			grp_q       <= '0;
			err_q       <= 1'b0;
			act_q       <= '0;
		end else if (step) begin
			if (is_last) begin
				phase_q     <= PH_LEAD;
				neg_q       <= 1'b0;
				par_q       <= 1'b0;
				int_q       <= '0;
				frac_q      <= '0;
				fc_q        <= '0;
				round_q     <= 1'b0;
				saw_int_q   <= 1'b0;
				saw_pt_q    <= 1'b0;
				saw_comma_q <= 1'b0;
				grp_q       <= '0;
				err_q       <= 1'b0;
				act_q       <= '0;
			end else begin
				phase_q     <= phase_d;
				neg_q       <= neg_n;
				par_q       <= par_n;
				int_q       <= int_n;
				frac_q      <= frac_n;
				fc_q        <= fc_n;
				round_q     <= round_n;
				saw_int_q   <= saw_int_n;
				saw_pt_q    <= saw_pt_n;
				saw_comma_q <= saw_comma_n;
				grp_q       <= grp_n;
				err_q       <= err_n;
				act_q       <= act_n;
			end
		end
	end

	a_lead_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LEAD |-> int_q == '0 && frac_q == '0 && !err_q && fc_q == '0)
		else $error("parse state not clear in leading whitespace");

	a_int_range: assert property (@(posedge clk) disable iff (!arst_n)
		int_q <= (neg_q ? NEG_LIMIT : POS_LIMIT))
		else $error("integer accumulator beyond limit");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		frac_q < pow10(act_q) && fc_q <= act_q + 5'd1)
		else $error("fraction accumulator or count out of range");

endmodule

[rtl/core/decimal_text_to_fixed_point.sv]
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Decimal text to signed 64-bit fixed point, scaled by ten to the number of
// fraction digits held in the configuration register, clamped to 18.
// ----------------------------------------------------------------------------
// result word: valid once the last byte has passed the s1, s2, s3 and output registers
// throughput: one byte per cycle, unless a text's last byte waits on a stalled s2
// results leave through an output register; a stalled sink fills the pipeline
// reset: parse state and pipeline cleared, fraction digit count set to 4
module decimal_text_to_fixed_point (
	input  logic                          clk,
	input  logic                          arst_n,
	dtfp_char_if.sink                     text,
	dtfp_result_if.source                 result,
	input  logic                          cfg_wr_en,
	input  logic [dtfp_pkg::DIGITS_W-1:0] cfg_wr_data
);
	import dtfp_pkg::*;

	logic [DIGITS_W-1:0]  digits_q;

	logic                 valid_s1;
	logic [CHAR_W-1:0]    char_s1;
	logic                 last_s1;

	dtfp_snap_t           snap;
	logic                 valid_s2;
	dtfp_snap_t           snap_s2;

	logic                 valid_s3;
	logic [VALUE_W:0]     total_s3;
	logic                 neg_s3;
	logic                 ok_s3;

	logic                 out_v_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 res_ok_q;

	logic                 out_free, s3_free, s2_free, s1_go, s2_go, s3_go, accept;
	logic [VALUE_W:0]     limit_ext;
	logic                 in_range;
	logic [VALUE_W-1:0]   value_d;

	assign out_free = !out_v_q || result.ready;
	assign s3_go    = valid_s3 && out_free;
	assign s3_free  = !valid_s3 || out_free;
	assign s2_go    = valid_s2 && s3_free;
	assign s2_free  = !valid_s2 || s3_free;
	assign s1_go    = valid_s1 && (!last_s1 || s2_free);
	assign text.ready = !valid_s1 || s1_go;
	assign accept   = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= RESET_DIGITS;
		end else if (cfg_wr_en) begin
			digits_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= text.char_code;
			last_s1 <= text.is_last;
		end
	end

	dtfp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (s1_go),
		.char_code  (char_s1),
		.is_last    (last_s1),
		.cfg_digits (digits_q),
		.snap       (snap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_go) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			snap_s2 <= snap;
		end
	end

	// integer and fraction parts with the rounding carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s2_go) begin
			valid_s3 <= 1'b1;
		end else if (s3_go) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			total_s3 <= {1'b0, snap_s2.int_mag} +
				{{(VALUE_W-FRAC_W+1){1'b0}}, snap_s2.frac_mag} +
				{{VALUE_W{1'b0}}, snap_s2.round_up};
			neg_s3   <= snap_s2.negative;
			ok_s3    <= snap_s2.syntax_ok;
		end
	end

	assign limit_ext = {1'b0, (neg_s3 ? NEG_LIMIT : POS_LIMIT)};
	assign in_range  = ok_s3 && (total_s3 <= limit_ext);
	assign value_d   = !in_range ? '0 :
		(neg_s3 ? (~total_s3[VALUE_W-1:0] + 64'd1) : total_s3[VALUE_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s3_go) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_go) begin
			value_q  <= value_d;
			res_ok_q <= in_range;
		end
	end

	assign result.valid        = out_v_q;
	assign result.scaled_value = value_q;
	assign result.valid_res    = res_ok_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !res_ok_q |-> value_q == '0)
		else $error("invalid result with nonzero value");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(valid_s3))
		else $error("result word without a finishing stage entry");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !s3_free |=> valid_s2 && $stable(snap_s2))
		else $error("stalled parse snapshot lost");

endmodule

[tb/decimal_text_to_fixed_point_tb.sv]
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_tb
// Drives decimal text into the converter one character word at a time and
// checks every result word against a bit-accurate bench parser or a typed table entry.
// A directed table comes first, then random texts in several fraction digit
// settings and sender/receiver idling mixes, with a long receiver hold-off.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_tb;
	import dtfp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               ok;
	} fixed_word_t;

	typedef struct {
		string              txt;
		bit                 typed;
		logic [VALUE_W-1:0] value;
		bit                 ok;
	} text_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [DIGITS_W-1:0] cfg_wr_data;

	dtfp_char_if   text_ch ();
	dtfp_result_if result_ch ();

	decimal_text_to_fixed_point dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text_ch),
		.result      (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// parser state of the bench
	logic [DIGITS_W-1:0] digits_reg;
	dtfp_phase_t         ph;
	bit                  neg, paren, saw_int, saw_pt, saw_cm, err, rnd;
	logic [VALUE_W-1:0]  int_mag, frac_mag;
	int                  frac_cnt, grp_len, act;

	fixed_word_t         pending_words[$];
	fixed_word_t         oldest_word;
	logic [CHAR_W-1:0]   text_buf[$];

	int                  errors = 0;
	int unsigned         cycle_cnt = 0;
	int                  idle_pct = 0;
	int                  stall_pct = 0;
	bit                  hold_req = 0;
	bit                  hold_ack = 0;
	int                  hold_left = 0;

	text_row_t dir_rows [25] = '{
		'{"0",                      1'b1, 64'd0,                      1'b1},
		'{"1",                      1'b1, 64'd10000,                  1'b1},
		'{"-1.5",                   1'b1, -64'sd15000,                1'b1},
		'{"(1,234.5)",              1'b1, 64'd12345000,               1'b1},
		'{"\t+12.34567 \n",         1'b0, 64'd0,                      1'b0},
		'{"1.23455",                1'b0, 64'd0,                      1'b0},
		'{"   ",                    1'b1, 64'd0,                      1'b0},
		'{"1 2",                    1'b1, 64'd0,                      1'b0},
		'{"12a",                    1'b1, 64'd0,                      1'b0},
		'{"(12",                    1'b1, 64'd0,                      1'b0},
		'{"(-12)",                  1'b1, 64'd0,                      1'b0},
		'{"(12)x",                  1'b1, 64'd0,                      1'b0},
		'{".",                      1'b1, 64'd0,                      1'b0},
		'{"-",                      1'b1, 64'd0,                      1'b0},
		'{"1,23",                   1'b1, 64'd0,                      1'b0},
		'{"1234,567",               1'b1, 64'd0,                      1'b0},
		'{",123",                   1'b1, 64'd0,                      1'b0},
		'{"12,345,678.9",           1'b0, 64'd0,                      1'b0},
		'{"1.2.3",                  1'b1, 64'd0,                      1'b0},
		'{".5",                     1'b0, 64'd0,                      1'b0},
		'{" 5. ",                   1'b0, 64'd0,                      1'b0},
		'{"922337203685477.5807",   1'b1, 64'h7FFF_FFFF_FFFF_FFFF,    1'b1},
		'{"-922337203685477.5808",  1'b1, 64'h8000_0000_0000_0000,    1'b1},
		'{"922337203685477.5808",   1'b1, 64'd0,                      1'b0},
		'{"922337203685477.58075",  1'b1, 64'd0,                      1'b0}
	};

	function automatic logic [VALUE_W-1:0] scale_pow(input int n);
		logic [VALUE_W-1:0] p;
		p = 64'd1;
		repeat (n) p = p * 64'd10;
		return p;
	endfunction

	function automatic bit is_blank(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [VALUE_W-1:0] mag_limit();
		return neg ? NEG_LIMIT : POS_LIMIT;
	endfunction

	function automatic int clamp_digits(input logic [DIGITS_W-1:0] d);
		return (d > MAX_DIGITS) ? int'(MAX_DIGITS) : int'(d);
	endfunction

	function automatic void clear_parse();
		ph       = PH_LEAD;
		neg      = 0;
		paren    = 0;
		int_mag  = '0;
		frac_mag = '0;
		frac_cnt = 0;
		rnd      = 0;
		saw_int  = 0;
		saw_pt   = 0;
		saw_cm   = 0;
		grp_len  = 0;
		err      = 0;
		act      = 0;
	endfunction

	function automatic void take_body(input logic [CHAR_W-1:0] c);
		bit                 dig;
		logic [VALUE_W-1:0] d;
		logic [VALUE_W-1:0] lim;
		dig = c >= CH_ZERO && c <= CH_NINE;
		d = dig ? 64'(c - CH_ZERO) : 64'd0;
		if (c == CH_POINT) begin
			if (saw_pt) begin
				err = 1;
			end else begin
				if (saw_cm && grp_len != 3)
					err = 1;
				saw_pt = 1;
			end
		end else if (saw_pt) begin
			if (!dig) begin
				err = 1;
			end else begin
				if (frac_cnt < act)
					frac_mag = frac_mag * 64'd10 + d;
				else if (frac_cnt == act)
					rnd = d >= 64'd5;
				if (frac_cnt <= act)
					frac_cnt++;
			end
		end else if (c == CH_COMMA) begin
			if (!saw_cm) begin
				if (grp_len == 0 || grp_len > 3)
					err = 1;
				saw_cm = 1;
			end else if (grp_len != 3) begin
				err = 1;
			end
			grp_len = 0;
		end else if (dig) begin
			lim = mag_limit() / scale_pow(act);
			if (grp_len < 4)
				grp_len++;
			saw_int = 1;
			if (d > lim || int_mag > (lim - d) / 64'd10)
				err = 1;
			else
				int_mag = int_mag * 64'd10 + d;
		end else begin
			err = 1;
		end
	endfunction

	function automatic void parse_char(input logic [CHAR_W-1:0] c);
		bit blank;
		blank = is_blank(c);
		case (ph)
			PH_LEAD: begin
				if (!blank) begin
					act = clamp_digits(digits_reg);
					ph = PH_BODY;
					if (c == CH_LPAREN)
						paren = 1;
					else if (c == CH_PLUS || c == CH_MINUS)
						neg = (c == CH_MINUS);
					else
						take_body(c);
				end
			end
			PH_BODY: begin
				if (blank) begin
					if (paren)
						err = 1;
					else
						ph = PH_TRAIL;
				end else if (c == CH_RPAREN && paren) begin
					ph = PH_CLOSED;
				end else begin
					take_body(c);
				end
			end
			PH_CLOSED: begin
				if (blank)
					ph = PH_TRAIL;
				else
					err = 1;
			end
			default: begin
				if (!blank)
					err = 1;
			end
		endcase
	endfunction

	function automatic fixed_word_t close_text();
		fixed_word_t        w;
		logic [VALUE_W-1:0] lim, fr, mg;
		lim = mag_limit();
		fr = frac_mag;
		w.value = '0;
		w.ok = 1'b0;
		if (err || ph == PH_LEAD) begin
		end else if (paren && ph != PH_CLOSED && ph != PH_TRAIL) begin
		end else if (!saw_int && frac_cnt == 0) begin
		end else if (!saw_pt && saw_cm && grp_len != 3) begin
		end else begin
			if (frac_cnt < act)
				fr = fr * scale_pow(act - frac_cnt);
			mg = int_mag * scale_pow(act);
			if (fr <= lim - mg) begin
				mg = mg + fr;
				if (!(rnd && mg == lim)) begin
					if (rnd)
						mg = mg + 64'd1;
					w.value = neg ? (64'd0 - mg) : mg;
					w.ok = 1'b1;
				end
			end
		end
		clear_parse();
		return w;
	endfunction

	function automatic logic [CHAR_W-1:0] rand_blank();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? CH_SPACE : 8'(int'(CH_TAB) + r);
	endfunction

	function automatic void build_text();
		int    kind, sign, int_len, act_n, ipos, pos;
		bit    use_commas, negish;
		string lim_s;
		text_buf.delete();
		kind = $urandom_range(99);
		sign = $urandom_range(3);
		negish = (sign == 2 || sign == 3);
		act_n = clamp_digits(digits_reg);
		repeat ($urandom_range(2)) text_buf.push_back(rand_blank());
		if (sign == 1)
			text_buf.push_back(CH_PLUS);
		else if (sign == 2)
			text_buf.push_back(CH_MINUS);
		else if (sign == 3)
			text_buf.push_back(CH_LPAREN);
		if (kind < 15) begin
			// digits at the int64 bound for this sign, at times pushed past it
			lim_s = negish ? "9223372036854775808" : "9223372036854775807";
			ipos = 19 - act_n;
			for (int i = 0; i < 19; i++) begin
				if (i == ipos && act_n > 0)
					text_buf.push_back(CH_POINT);
				text_buf.push_back(8'(lim_s[i]));
			end
			case ($urandom_range(2))
				1: text_buf[text_buf.size()-1] = text_buf[text_buf.size()-1] + 8'd1;
				2: text_buf.push_back(8'(int'(CH_ZERO) + $urandom_range(9)));
				default: ;
			endcase
		end else begin
			int_len = $urandom_range(0, ($urandom_range(3) == 0) ? 19 : 5);
			use_commas = int_len > 3 && $urandom_range(1);
			for (int i = 0; i < int_len; i++) begin
				if (use_commas && i > 0 && (int_len - i) % 3 == 0)
					text_buf.push_back(CH_COMMA);
				text_buf.push_back(8'(int'(CH_ZERO) + $urandom_range(9)));
			end
			if (int_len == 0 || $urandom_range(1)) begin
				text_buf.push_back(CH_POINT);
				repeat ($urandom_range(0, $urandom_range(1) ? 20 : 5))
					text_buf.push_back(8'(int'(CH_ZERO) + $urandom_range(9)));
			end
		end
		if (sign == 3 && $urandom_range(9) != 0)
			text_buf.push_back(CH_RPAREN);
		repeat ($urandom_range(2)) text_buf.push_back(rand_blank());
		// broken texts
		if (kind >= 80) begin
			pos = $urandom_range(text_buf.size() - 1);
			case ($urandom_range(2))
				0: text_buf[pos] = 8'($urandom_range(255));
				1: text_buf.insert(pos, 8'($urandom_range(255)));
				default: begin
					if (text_buf.size() > 1)
						text_buf.delete(pos);
				end
			endcase
		end
	endfunction

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL decimal_text_to_fixed_point");
			$finish;
		end
	end

	// result sink with random stalls and a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result word value %0d valid %0b", $time,
					$signed(result_ch.scaled_value), result_ch.valid_res);
				errors++;
			end else begin
				oldest_word = pending_words.pop_front();
				if (result_ch.scaled_value !== oldest_word.value ||
					result_ch.valid_res !== oldest_word.ok) begin
					$display("%0t: mismatch expected %0d valid %0b, actual %0d valid %0b",
						$time, $signed(oldest_word.value), oldest_word.ok,
						$signed(result_ch.scaled_value), result_ch.valid_res);
					errors++;
				end
			end
		end
	end

	task automatic send_word(input logic [CHAR_W-1:0] c, input bit last);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			text_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		text_ch.valid <= 1'b1;
		text_ch.char_code <= c;
		text_ch.is_last <= last;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		parse_char(c);
	endtask

	task automatic send_text(input bit typed, input fixed_word_t typed_word);
		fixed_word_t w;
		for (int i = 0; i < text_buf.size(); i++)
			send_word(text_buf[i], i == text_buf.size() - 1);
		w = close_text();
		pending_words.push_back(typed ? typed_word : w);
	endtask

	task automatic wait_results();
		text_ch.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_digits(input logic [DIGITS_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		digits_reg = v;
		@(posedge clk);
	endtask

	initial begin
		int                  sent;
		fixed_word_t         tw;
		int                  idle_plan [4]  = '{0, 75, 0, 28};
		int                  stall_plan [4] = '{0, 0, 75, 28};
		logic [DIGITS_W-1:0] digit_plan [8] = '{5'd0, 5'd18, 5'd31, 5'd9,
			5'd1, 5'd17, 5'd19, 5'd2};
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		text_ch.valid = 1'b0;
		text_ch.char_code = '0;
		text_ch.is_last = 1'b0;
		result_ch.ready = 1'b0;
		digits_reg = RESET_DIGITS;
		clear_parse();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			text_buf.delete();
			for (int i = 0; i < dir_rows[r].txt.len(); i++)
				text_buf.push_back(8'(dir_rows[r].txt[i]));
			tw.value = dir_rows[r].value;
			tw.ok = dir_rows[r].ok;
			send_text(dir_rows[r].typed, tw);
		end
		wait_results();
		repeat (10) @(posedge clk);

		for (int h = 0; h < 8; h++) begin
			idle_pct = idle_plan[h/2];
			stall_pct = stall_plan[h/2];
			set_digits(digit_plan[h]);
			if (h == 1)
				hold_req <= ~hold_req;
			sent = 0;
			while (sent < 75) begin
				build_text();
				send_text(1'b0, '0);
				sent += text_buf.size();
				if ($urandom_range(15) == 0)
					wait_results();
			end
			wait_results();
			repeat (10) @(posedge clk);
		end

		if (errors == 0)
			$display("PASS decimal_text_to_fixed_point");
		else
			$display("FAIL decimal_text_to_fixed_point");
		$finish;
	end

endmodule

[decimal_text_to_fixed_point.f]
rtl/core/dtfp_pkg.sv
rtl/core/dtfp_char_if.sv
rtl/core/dtfp_result_if.sv
rtl/core/dtfp_parser.sv
rtl/core/decimal_text_to_fixed_point.sv
tb/decimal_text_to_fixed_point_tb.sv
